>>> src/apsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg: shared types and constants for the all-pairs shortest path engine
// Node/address widths, distance format, command codes and the RAM request.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int unsigned MAX_NODES   = 16;
  localparam int unsigned NODE_W      = $clog2(MAX_NODES);
  localparam int unsigned CELLS       = MAX_NODES * MAX_NODES;
  localparam int unsigned ADDR_W      = 2 * NODE_W;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned DIST_W      = 20;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  // one write port, two read ports
  typedef struct packed {
    logic                     ra_en;
    logic [ADDR_W-1:0]        ra_addr;
    logic                     rb_en;
    logic [ADDR_W-1:0]        rb_addr;
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DIST_W-1:0] wdata;
  } ram_req_t;

  // clamp a two-leg sum back into the distance range
  function automatic logic signed [DIST_W-1:0] clamp_sum(
    input logic signed [DIST_W:0] sum
  );
    logic signed [DIST_W-1:0] res;
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      res = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      res = sum[DIST_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> src/apsp_dist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_dist_ram: distance matrix storage
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module apsp_dist_ram (
  input  logic                             clk_i,
  input  apsp_pkg::ram_req_t               req_i,
  output logic signed [apsp_pkg::DIST_W-1:0] rd_a_o,
  output logic signed [apsp_pkg::DIST_W-1:0] rd_b_o
);

  logic signed [apsp_pkg::DIST_W-1:0] mem [apsp_pkg::CELLS];
  logic signed [apsp_pkg::DIST_W-1:0] rd_a_q;
  logic signed [apsp_pkg::DIST_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.ra_en) begin
      rd_a_q <= mem[req_i.ra_addr];
    end
    if (req_i.rb_en) begin
      rd_b_q <= mem[req_i.rb_addr];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

>>> src/all_pairs_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path: Floyd-Warshall engine, up to 16 nodes
// Command-driven: clear, load edge, compute all pairs, read distance.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted on a rising edge with start_i high and
// busy_o low. Clear, load and read can follow each other back to back;
// busy_o stays low for them. A read returns its result
// on distance_o/unreachable_o in the cycle right after acceptance, flagged by
// result_valid_o for exactly one cycle. The receiver cannot stall, so it
// must capture the result in that cycle. Compute raises busy_o until done.
// It walks intermediate k, source s and destination d with one shared
// adder/comparator and the matrix RAM. For each (k,s) row it checks the s->k
// leg; when s differs from k and the leg is finite it latches it, then for
// each d it either skips or reads, adds/clamps and compares/writes back.
// Validity (finite vs. infinite) lives in per-entry flops, so reset and clear
// take effect at once; there is no clearing pass. The user must write
// node_count via cfg_we_i/cfg_wdata_i only while idle; the block does not
// enforce this. node_count 0 acts as 1, above 16 acts as 16.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config
  input  logic                                   cfg_we_i,
  input  logic [apsp_pkg::CNT_W-1:0]             cfg_wdata_i,
  // command
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             cmd_i,
  input  logic [apsp_pkg::NODE_W-1:0]            src_node_i,
  input  logic [apsp_pkg::NODE_W-1:0]            dst_node_i,
  input  logic signed [apsp_pkg::WEIGHT_BITS-1:0] edge_weight_i,
  // result
  output logic                                   result_valid_o,
  output logic signed [apsp_pkg::DIST_W-1:0]     distance_o,
  output logic                                   unreachable_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,   // check s->k leg, fetch it
    ST_ROWW,  // latch s->k leg
    ST_COL,   // check k->d leg, fetch k->d and s->d
    ST_ADD,   // add and clamp
    ST_UPD    // compare, write back
  } state_e;

  localparam logic [apsp_pkg::CNT_W-1:0] NODES_MAX = apsp_pkg::CNT_W'(apsp_pkg::MAX_NODES);

  state_e                               state_q;
  logic [apsp_pkg::CNT_W-1:0]           node_count_q;
  logic [apsp_pkg::CELLS-1:0]           valid_q;
  logic [apsp_pkg::NODE_W-1:0]          k_q, s_q, d_q;
  logic signed [apsp_pkg::DIST_W-1:0]   sk_q;
  logic signed [apsp_pkg::DIST_W-1:0]   sum_q;
  logic                                 rd_pend_q;
  logic                                 rd_ok_q;

  apsp_pkg::ram_req_t                   ram_req;
  logic signed [apsp_pkg::DIST_W-1:0]   rd_a, rd_b;

  logic [apsp_pkg::NODE_W-1:0]          n_last;
  logic                                 accept;
  apsp_pkg::cmd_e                       cmd;
  logic [apsp_pkg::ADDR_W-1:0]          io_addr;
  logic                                 io_ok;
  logic [apsp_pkg::ADDR_W-1:0]          sk_addr, kd_addr, sd_addr;
  logic                                 row_live, col_live, upd;
  logic                                 d_last, s_last, k_last;

  // effective last node index
  always_comb begin
    if (node_count_q == '0) begin
      n_last = '0;
    end else if (node_count_q > NODES_MAX) begin
      n_last = apsp_pkg::NODE_W'(apsp_pkg::MAX_NODES - 1);
    end else begin
      n_last = apsp_pkg::NODE_W'(node_count_q - apsp_pkg::CNT_W'(1));
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign cmd     = apsp_pkg::cmd_e'(cmd_i);
  assign io_addr = {src_node_i, dst_node_i};
  assign io_ok   = (src_node_i <= n_last) && (dst_node_i <= n_last);

  assign sk_addr = {s_q, k_q};
  assign kd_addr = {k_q, d_q};
  assign sd_addr = {s_q, d_q};

  // skip rules: k==s, k==d, s==d and infinite legs
  assign row_live = (s_q != k_q) && valid_q[sk_addr];
  assign col_live = (d_q != k_q) && (d_q != s_q) && valid_q[kd_addr];
  assign upd      = !valid_q[sd_addr] || (rd_b > sum_q);

  assign d_last = (d_q == n_last);
  assign s_last = (s_q == n_last);
  assign k_last = (k_q == n_last);

  // RAM port steering
  always_comb begin
    ram_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd == apsp_pkg::CMD_LOAD && io_ok) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = io_addr;
          ram_req.wdata = apsp_pkg::DIST_W'(edge_weight_i);
        end
        if (accept && cmd == apsp_pkg::CMD_READ) begin
          ram_req.ra_en   = 1'b1;
          ram_req.ra_addr = io_addr;
        end
      end
      ST_ROW: begin
        ram_req.ra_en   = row_live;
        ram_req.ra_addr = sk_addr;
      end
      ST_COL: begin
        ram_req.ra_en   = col_live;
        ram_req.ra_addr = kd_addr;
        ram_req.rb_en   = col_live;
        ram_req.rb_addr = sd_addr;
      end
      ST_UPD: begin
        ram_req.we    = upd;
        ram_req.waddr = sd_addr;
        ram_req.wdata = sum_q;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  apsp_dist_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // payload: latched leg and clamped sum, both legs sign-extended by one bit
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROWW) begin
      sk_q <= rd_a;
    end
    if (state_q == ST_ADD) begin
      sum_q <= apsp_pkg::clamp_sum((apsp_pkg::DIST_W + 1)'(sk_q) +
                                   (apsp_pkg::DIST_W + 1)'(rd_a));
    end
  end

  // sequencer, counters, validity flops, read result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NODES_MAX;
      valid_q      <= '0;
      k_q          <= '0;
      s_q          <= '0;
      d_q          <= '0;
      rd_pend_q    <= 1'b0;
      rd_ok_q      <= 1'b0;
    end else begin
      rd_pend_q <= accept && (cmd == apsp_pkg::CMD_READ);
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (ram_req.we) begin
        valid_q[ram_req.waddr] <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              apsp_pkg::CMD_CLEAR: begin
                valid_q <= '0;
              end
              apsp_pkg::CMD_COMPUTE: begin
                k_q     <= '0;
                s_q     <= '0;
                state_q <= ST_ROW;
              end
              apsp_pkg::CMD_READ: begin
                rd_ok_q <= io_ok && valid_q[io_addr];
              end
              default: begin
                // load handled by the write port
              end
            endcase
          end
        end
        ST_ROW: begin
          if (row_live) begin
            d_q     <= '0;
            state_q <= ST_ROWW;
          end else if (!s_last) begin
            s_q <= s_q + 1'b1;
          end else if (!k_last) begin
            s_q <= '0;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_ROWW: begin
          state_q <= ST_COL;
        end
        ST_COL, ST_UPD: begin
          if (state_q == ST_COL && col_live) begin
            state_q <= ST_ADD;
          end else if (!d_last) begin
            d_q     <= d_q + 1'b1;
            state_q <= ST_COL;
          end else if (!s_last) begin
            s_q     <= s_q + 1'b1;
            state_q <= ST_ROW;
          end else if (!k_last) begin
            s_q     <= '0;
            k_q     <= k_q + 1'b1;
            state_q <= ST_ROW;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_ADD: begin
          state_q <= ST_UPD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = rd_pend_q;
  assign distance_o     = rd_ok_q ? rd_a : '0;
  assign unreachable_o  = !rd_ok_q;

endmodule
